// ===== hw/rtl/hbc_pkg.sv =====
`default_nettype none
package hbc_pkg;

  localparam int CHAR_W        = 7;
  localparam int SIZE_W        = 3;
  localparam int KEY_W         = 28;
  localparam int KEY_ROWS      = 4;
  localparam int INDEX_W       = 3;
  localparam int DEF_MAX_BLOCK = 4;
  localparam int ALPHABET      = 95;
  localparam int BASE_CHAR     = 32;
  localparam int PAD_CHAR      = 120;
  localparam int PAD_CODE      = PAD_CHAR - BASE_CHAR;

  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = SIZE_W'(2);

  typedef enum logic [INDEX_W-1:0] {
    REG_BLOCK_SIZE = 3'd0,
    REG_KEY_ROW_0  = 3'd1,
    REG_KEY_ROW_1  = 3'd2,
    REG_KEY_ROW_2  = 3'd3,
    REG_KEY_ROW_3  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] plain_char;
    logic              message_end;
  } plain_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cipher_char;
    logic              block_last;
    logic              message_last;
  } cipher_item_t;

  typedef struct packed {
    logic block_last;
    logic message_last;
  } row_tag_t;

  // identity matrix, one 7-bit entry per column
  function automatic logic [KEY_W-1:0] key_reset(input int row);
    logic [KEY_W-1:0] v;
    v = '0;
    v[CHAR_W*row] = 1'b1;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hbc_blocker.sv =====
`default_nettype none
module hbc_blocker
  import hbc_pkg::*;
#(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK,
  localparam int NW = $clog2(MAX_BLOCK + 1),
  localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [NW-1:0]                      n_act,
  input  wire logic                               size_clear,
  input  wire logic                               plain_valid,
  output logic                                    plain_ready,
  input  wire plain_item_t                        plain,
  input  wire logic                               pend_take,
  output logic                                    pend_valid,
  output logic [MAX_BLOCK-1:0][CHAR_W-1:0]        pend_vec,
  output logic [NW-1:0]                           pend_n,
  output logic                                    pend_end
);

  logic [NW-1:0]     fill;
  logic [NW-1:0]     fill_next;
  logic [CHAR_W-1:0] buffer [MAX_BLOCK];
  logic [CHAR_W-1:0] mapped;
  logic              accept;
  logic              complete;
  logic [MAX_BLOCK-1:0][CHAR_W-1:0] vec_next;

  assign plain_ready = !pend_valid || pend_take;
  assign accept      = plain_valid && plain_ready;
  assign mapped      = CHAR_W'(plain.plain_char - CHAR_W'(BASE_CHAR));
  assign fill_next   = fill + NW'(1);
  assign complete    = (fill_next >= n_act) || plain.message_end;

  // positions past the last character are padded
  always_comb begin
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (NW'(j) < fill) begin
        vec_next[j] = buffer[j];
      end else if (NW'(j) == fill) begin
        vec_next[j] = mapped;
      end else begin
        vec_next[j] = CHAR_W'(PAD_CODE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_take) begin
        pend_valid <= 1'b0;
      end
      if (size_clear) begin
        fill <= '0;
      end else if (accept) begin
        if (complete) begin
          fill       <= '0;
          pend_valid <= 1'b1;
        end else begin
          fill <= fill_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buffer[fill[IW-1:0]] <= mapped;
      if (complete) begin
        pend_vec <= vec_next;
        pend_n   <= n_act;
        pend_end <= plain.message_end;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hbc_rowmul.sv =====
`default_nettype none
module hbc_rowmul
  import hbc_pkg::*;
#(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK,
  localparam int NW = $clog2(MAX_BLOCK + 1),
  localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1,
  localparam int SUM_W = $clog2(MAX_BLOCK * 127 * 127 + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [KEY_ROWS-1:0][KEY_W-1:0]     key_row,
  input  wire logic                               pend_valid,
  input  wire logic [MAX_BLOCK-1:0][CHAR_W-1:0]   pend_vec,
  input  wire logic [NW-1:0]                      pend_n,
  input  wire logic                               pend_end,
  output logic                                    pend_take,
  input  wire logic                               advance,
  output logic                                    s1_valid,
  output logic [SUM_W-1:0]                        s1_sum,
  output row_tag_t                                s1_tag
);

  logic                             busy;
  logic [MAX_BLOCK-1:0][CHAR_W-1:0] vec;
  logic [NW-1:0]                    n;
  logic                             msg_end;
  logic [NW-1:0]                    row;
  logic                             issue;
  logic                             last_row;
  logic [CHAR_W-1:0]                kmat [MAX_BLOCK][MAX_BLOCK];
  logic [2*CHAR_W-1:0]              prod [MAX_BLOCK];
  logic [SUM_W-1:0]                 sum;

  assign issue     = busy && advance;
  assign last_row  = (row == n - NW'(1));
  assign pend_take = pend_valid && (!busy || (issue && last_row));

  // entries outside the four key registers read as zero
  always_comb begin
    for (int r = 0; r < MAX_BLOCK; r++) begin
      for (int j = 0; j < MAX_BLOCK; j++) begin
        if (r < KEY_ROWS && j < KEY_ROWS) begin
          kmat[r][j] = key_row[r % KEY_ROWS][CHAR_W*(j % KEY_ROWS) +: CHAR_W];
        end else begin
          kmat[r][j] = '0;
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if (NW'(j) < n) begin
        prod[j] = kmat[row[IW-1:0]][j] * vec[j];
      end else begin
        prod[j] = '0;
      end
      sum = sum + SUM_W'(prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (pend_take) begin
        busy <= 1'b1;
      end else if (issue && last_row) begin
        busy <= 1'b0;
      end
      if (advance) begin
        s1_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      vec     <= pend_vec;
      n       <= pend_n;
      msg_end <= pend_end;
      row     <= '0;
    end else if (issue) begin
      row <= row + NW'(1);
    end
    if (advance) begin
      s1_sum              <= sum;
      s1_tag.block_last   <= last_row;
      s1_tag.message_last <= last_row && msg_end;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hbc_mod95.sv =====
`default_nettype none
module hbc_mod95
  import hbc_pkg::*;
#(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK,
  localparam int SUM_W = $clog2(MAX_BLOCK * 127 * 127 + 1),
  localparam int SHIFT = SUM_W + 1,
  localparam longint RECIP = (64'd1 << SHIFT) / ALPHABET,
  localparam int RW = $clog2(RECIP + 1),
  localparam int PW = SUM_W + RW
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s1_valid,
  input  wire logic [SUM_W-1:0] s1_sum,
  input  wire row_tag_t         s1_tag,
  output logic                  advance,
  output logic                  cipher_valid,
  input  wire logic             cipher_ready,
  output cipher_item_t          cipher
);

  logic               s2_valid;
  logic [SUM_W-1:0]   s2_sum;
  logic [SUM_W-1:0]   s2_q;
  row_tag_t           s2_tag;
  logic [PW-1:0]      prod;
  logic [SUM_W+6:0]   q95;
  logic [7:0]         rem;
  logic [7:0]         rem_fix;

  assign advance = !cipher_valid || cipher_ready;

  // quotient estimate is low by at most one
  assign prod = PW'(s1_sum) * PW'(RECIP);
  assign q95  = ({7'd0, s2_q} << 6) + ({7'd0, s2_q} << 5) - {7'd0, s2_q};
  assign rem  = 8'(({7'd0, s2_sum} - q95));

  always_comb begin
    if (rem >= 8'(ALPHABET)) begin
      rem_fix = rem - 8'(ALPHABET);
    end else begin
      rem_fix = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      cipher_valid <= 1'b0;
    end else if (advance) begin
      s2_valid     <= s1_valid;
      cipher_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_sum              <= s1_sum;
      s2_q                <= SUM_W'(prod >> SHIFT);
      s2_tag              <= s1_tag;
      cipher.cipher_char  <= CHAR_W'(rem_fix) + CHAR_W'(BASE_CHAR);
      cipher.block_last   <= s2_tag.block_last;
      cipher.message_last <= s2_tag.message_last;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/hill_block_cipher_mod95_unit.sv =====
// Hill cipher over the 95 printable ASCII characters.
// plain channel (valid/ready) takes one character per transfer; message_end
// marks the last character of a message. cipher channel (valid/ready) gives
// one cipher character per transfer, with block_last on the last character of
// each block and message_last on the last character of a message.
// A block of n = block_size characters is multiplied by the key matrix
// modulo 95; a short final block is padded with 'x'.
// Throughput: one character in and one out per cycle while cipher_ready is high;
// the key product runs one matrix row per cycle through a three-register
// pipeline. A padded block can stall plain_ready until the row multiplier takes it.
// The first cipher character of a block follows the character that completes
// it through the holding register, the s1 and s2 registers and the output register.
// When cipher_ready is low the output register and pipeline hold; one
// finished block can wait in a holding register before plain_ready drops.
// Reset: block_size 2, identity key, empty buffer, nothing in flight.
// The user must write registers through wr_en/wr_index/wr_data while idle, unchecked
// by the block itself; writing block_size discards a partial block.
`default_nettype none
module hill_block_cipher_mod95_unit
  import hbc_pkg::*;
#(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK,
  localparam int NW = $clog2(MAX_BLOCK + 1),
  localparam int SUM_W = $clog2(MAX_BLOCK * 127 * 127 + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [INDEX_W-1:0] wr_index,
  input  wire logic [KEY_W-1:0]   wr_data,
  input  wire logic               plain_valid,
  output logic                    plain_ready,
  input  wire plain_item_t        plain,
  output logic                    cipher_valid,
  input  wire logic               cipher_ready,
  output cipher_item_t            cipher
);

  logic [SIZE_W-1:0]                block_size;
  logic [KEY_ROWS-1:0][KEY_W-1:0]   key_row;
  logic [NW-1:0]                    n_act;
  logic                             size_clear;
  logic                             pend_valid;
  logic                             pend_take;
  logic [MAX_BLOCK-1:0][CHAR_W-1:0] pend_vec;
  logic [NW-1:0]                    pend_n;
  logic                             pend_end;
  logic                             advance;
  logic                             s1_valid;
  logic [SUM_W-1:0]                 s1_sum;
  row_tag_t                         s1_tag;

  assign size_clear = wr_en && (cfg_reg_t'(wr_index) == REG_BLOCK_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RESET;
      for (int r = 0; r < KEY_ROWS; r++) begin
        key_row[r] <= key_reset(r);
      end
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_BLOCK_SIZE: block_size <= wr_data[SIZE_W-1:0];
        REG_KEY_ROW_0:  key_row[0] <= wr_data;
        REG_KEY_ROW_1:  key_row[1] <= wr_data;
        REG_KEY_ROW_2:  key_row[2] <= wr_data;
        REG_KEY_ROW_3:  key_row[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, large sizes saturate
  always_comb begin
    if (block_size == '0) begin
      n_act = NW'(1);
    end else if (int'(block_size) > MAX_BLOCK) begin
      n_act = NW'(MAX_BLOCK);
    end else begin
      n_act = NW'(block_size);
    end
  end

  hbc_blocker #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_blocker (
    .clk         (clk),
    .rst         (rst),
    .n_act       (n_act),
    .size_clear  (size_clear),
    .plain_valid (plain_valid),
    .plain_ready (plain_ready),
    .plain       (plain),
    .pend_take   (pend_take),
    .pend_valid  (pend_valid),
    .pend_vec    (pend_vec),
    .pend_n      (pend_n),
    .pend_end    (pend_end)
  );

  hbc_rowmul #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_rowmul (
    .clk        (clk),
    .rst        (rst),
    .key_row    (key_row),
    .pend_valid (pend_valid),
    .pend_vec   (pend_vec),
    .pend_n     (pend_n),
    .pend_end   (pend_end),
    .pend_take  (pend_take),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_sum     (s1_sum),
    .s1_tag     (s1_tag)
  );

  hbc_mod95 #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_mod95 (
    .clk          (clk),
    .rst          (rst),
    .s1_valid     (s1_valid),
    .s1_sum       (s1_sum),
    .s1_tag       (s1_tag),
    .advance      (advance),
    .cipher_valid (cipher_valid),
    .cipher_ready (cipher_ready),
    .cipher       (cipher)
  );

endmodule
`default_nettype wire

// ===== verif/hill_cipher_check.sv =====
`timescale 1ns / 1ps
module hill_cipher_check
  import hbc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [INDEX_W-1:0] wr_index,
  input  wire logic [KEY_W-1:0]   wr_data,
  input  wire logic               plain_valid,
  input  wire logic               plain_ready,
  input  wire plain_item_t        plain,
  input  wire logic               cipher_valid,
  input  wire logic               cipher_ready,
  input  wire cipher_item_t       cipher,
  output int                      mismatches,
  output int                      cipher_owed,
  output int                      cipher_seen
);

  localparam int MAX_N = DEF_MAX_BLOCK;
  localparam int PRINT_CAP = 40;

  logic [SIZE_W-1:0] size_reg;
  logic [KEY_W-1:0]  key_row [KEY_ROWS];
  logic [CHAR_W-1:0] held [MAX_N];
  int                held_count;
  cipher_item_t      expected_cipher [$];

  initial begin
    mismatches = 0;
    cipher_owed = 0;
    cipher_seen = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t: cipher mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // buffer one character; a full block or a message end yields the block's cipher
  task automatic encipher_char(input plain_item_t item);
    int                n;
    int                acc;
    logic [CHAR_W-1:0] vec [MAX_N];
    cipher_item_t      c;
    n = int'(size_reg);
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    if (held_count >= n) held_count = 0;
    held[held_count] = item.plain_char - CHAR_W'(BASE_CHAR);
    held_count++;
    if (held_count < n && !item.message_end) return;
    for (int j = 0; j < n; j++) begin
      vec[j] = (j < held_count) ? held[j] : CHAR_W'(PAD_CODE);
    end
    for (int r = 0; r < n; r++) begin
      acc = 0;
      for (int j = 0; j < n; j++) begin
        acc += int'(key_row[r][CHAR_W*j +: CHAR_W]) * int'(vec[j]);
      end
      c.cipher_char  = CHAR_W'(acc % ALPHABET + BASE_CHAR);
      c.block_last   = (r == n - 1);
      c.message_last = item.message_end && (r == n - 1);
      expected_cipher.push_back(c);
    end
    held_count = 0;
  endtask

  task automatic compare_cipher(input cipher_item_t got);
    cipher_item_t want;
    cipher_seen++;
    if (expected_cipher.size() == 0) begin
      report("cipher transfer with nothing owed, char", 32'(got.cipher_char), 32'(0));
      return;
    end
    want = expected_cipher.pop_front();
    if (got.cipher_char !== want.cipher_char) begin
      report("cipher_char", 32'(got.cipher_char), 32'(want.cipher_char));
    end
    if (got.block_last !== want.block_last) begin
      report("block_last", 32'(got.block_last), 32'(want.block_last));
    end
    if (got.message_last !== want.message_last) begin
      report("message_last", 32'(got.message_last), 32'(want.message_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_reg = BLOCK_SIZE_RESET;
      for (int r = 0; r < KEY_ROWS; r++) key_row[r] = KEY_W'(1) << (CHAR_W * r);
      held_count = 0;
      expected_cipher.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_BLOCK_SIZE: begin
            size_reg = wr_data[SIZE_W-1:0];
            held_count = 0;
          end
          REG_KEY_ROW_0, REG_KEY_ROW_1, REG_KEY_ROW_2, REG_KEY_ROW_3: begin
            key_row[int'(wr_index) - int'(REG_KEY_ROW_0)] = wr_data;
          end
          default: ;
        endcase
      end
      if (plain_valid && plain_ready) encipher_char(plain);
      if (cipher_valid && cipher_ready) compare_cipher(cipher);
    end
    cipher_owed <= expected_cipher.size();
  end

endmodule

// ===== verif/hill_block_cipher_mod95_unit_test.sv =====
`timescale 1ns / 1ps
module hill_block_cipher_mod95_unit_test;
  import hbc_pkg::*;

  localparam int RANDOM_CHARS  = 480;
  localparam int LONG_HOLD     = 160;
  localparam int SETTLE_CYCLES = 12;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic [INDEX_W-1:0] wr_index = '0;
  logic [KEY_W-1:0]   wr_data = '0;
  logic               plain_valid = 1'b0;
  logic               plain_ready;
  plain_item_t        plain = '0;
  logic               cipher_valid;
  logic               cipher_ready = 1'b0;
  cipher_item_t       cipher;

  int mismatches;
  int cipher_owed;
  int cipher_seen;
  int chars_sent = 0;
  int reg_writes = 0;
  int burst_left = 0;
  bit steady = 1'b0;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  hill_block_cipher_mod95_unit uut (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .plain_valid  (plain_valid),
    .plain_ready  (plain_ready),
    .plain        (plain),
    .cipher_valid (cipher_valid),
    .cipher_ready (cipher_ready),
    .cipher       (cipher)
  );

  hill_cipher_check cipher_check (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .plain_valid  (plain_valid),
    .plain_ready  (plain_ready),
    .plain        (plain),
    .cipher_valid (cipher_valid),
    .cipher_ready (cipher_ready),
    .cipher       (cipher),
    .mismatches   (mismatches),
    .cipher_owed  (cipher_owed),
    .cipher_seen  (cipher_seen)
  );

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // cipher side: changing stall patterns, plus a long hold-off on request
  initial begin : receiver
    int mode;
    int tick;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        cipher_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (tick % 48 == 0) mode = $urandom_range(0, 3);
      tick++;
      case (mode)
        0: cipher_ready <= 1'b1;
        1: cipher_ready <= ($urandom_range(0, 3) != 0);
        2: cipher_ready <= ($urandom_range(0, 2) == 0);
        default: cipher_ready <= (tick % 5 != 0);
      endcase
    end
  end

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [KEY_W-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic finish_writes();
    wr_en <= 1'b0;
  endtask

  // wait until every owed cipher char is out and the pipeline has drained
  task automatic settle();
    plain_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (cipher_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send(input plain_item_t item);
    plain <= item;
    plain_valid <= 1'b1;
    @(posedge clk);
    while (!plain_ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic offer(input logic [CHAR_W-1:0] ch, input logic last);
    int          gap;
    plain_item_t item;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (steady || $urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        plain_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item.plain_char = ch;
    item.message_end = last;
    send(item);
  endtask

  // mostly printable, now and then any 7-bit code
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 19) == 0) return CHAR_W'($urandom);
    return CHAR_W'($urandom_range(BASE_CHAR, BASE_CHAR + ALPHABET - 1));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key_row();
    logic [KEY_W-1:0] v;
    v = '0;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2, 3: v = KEY_W'($urandom);
      default: begin
        for (int j = 0; j < KEY_ROWS; j++) begin
          v[CHAR_W*j +: CHAR_W] = CHAR_W'($urandom_range(0, ALPHABET - 1));
        end
      end
    endcase
    return v;
  endfunction

  task automatic load_random_key();
    for (int r = 0; r < KEY_ROWS; r++) begin
      write_reg(INDEX_W'(int'(REG_KEY_ROW_0) + r), pick_key_row());
    end
  endtask

  task automatic send_message(input int len, input bit closed);
    for (int i = 0; i < len; i++) offer(pick_char(), closed && (i == len - 1));
  endtask

  initial begin : stimulus
    int directed_chars;
    int phase;
    int target;
    int start;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: n = 2, identity key
    settle();
    offer(CHAR_W'(BASE_CHAR), 1'b0);
    offer(CHAR_W'(BASE_CHAR + ALPHABET - 1), 1'b1);
    offer(CHAR_W'("A"), 1'b1);
    offer(7'd0, 1'b0);
    offer(7'd127, 1'b0);
    offer(7'd31, 1'b1);

    // largest block, every key entry at its maximum, three pads
    settle();
    write_reg(REG_BLOCK_SIZE, KEY_W'(4));
    for (int r = 0; r < KEY_ROWS; r++) write_reg(INDEX_W'(int'(REG_KEY_ROW_0) + r), '1);
    finish_writes();
    for (int i = 0; i < 4; i++) offer(CHAR_W'(BASE_CHAR + ALPHABET - 1), i == 3);
    offer(CHAR_W'(BASE_CHAR + ALPHABET - 1), 1'b1);

    // block size zero acts as one; zero key row
    settle();
    write_reg(REG_BLOCK_SIZE, KEY_W'(0));
    write_reg(REG_KEY_ROW_0, '0);
    finish_writes();
    offer(CHAR_W'("2"), 1'b0);
    offer(CHAR_W'("3"), 1'b1);

    // oversize block size saturates; unused indexes are ignored
    settle();
    write_reg(REG_BLOCK_SIZE, '1);
    load_random_key();
    write_reg(INDEX_W'(int'(REG_KEY_ROW_3) + 1), '1);
    write_reg('1, '1);
    finish_writes();
    for (int i = 0; i < 5; i++) offer(pick_char(), 1'b0);

    // size write drops the partial block, key write keeps it
    settle();
    write_reg(REG_BLOCK_SIZE, KEY_W'(3));
    finish_writes();
    offer(CHAR_W'("h"), 1'b0);
    offer(CHAR_W'("i"), 1'b0);
    settle();
    write_reg(REG_KEY_ROW_1, pick_key_row());
    finish_writes();
    offer(CHAR_W'("!"), 1'b0);
    offer(CHAR_W'("~"), 1'b1);
    directed_chars = chars_sent;

    phase = 0;
    while (chars_sent - directed_chars < RANDOM_CHARS) begin
      settle();
      if (phase % 4 != 3) begin
        if ($urandom_range(0, 9) < 8) write_reg(REG_BLOCK_SIZE, KEY_W'($urandom_range(1, 4)));
        else write_reg(REG_BLOCK_SIZE, KEY_W'($urandom_range(0, 7)));
      end
      load_random_key();
      if ($urandom_range(0, 7) == 0) begin
        write_reg(INDEX_W'($urandom_range(int'(REG_KEY_ROW_3) + 1, 7)), KEY_W'($urandom));
      end
      finish_writes();
      steady = (phase == 2 || phase == 9);
      if (steady) hold_request = 1'b1;
      target = $urandom_range(20, 50);
      start = chars_sent;
      while (chars_sent - start < target) begin
        send_message($urandom_range(1, 10), $urandom_range(0, 4) != 0);
      end
      steady = 1'b0;
      phase++;
    end

    settle();
    $display("run covered %0d plaintext characters and %0d cipher characters in %0d phases",
             chars_sent, cipher_seen, phase);
    $display("with %0d register writes: block sizes 0..7, extreme keys, padding, long stalls",
             reg_writes);
    if (mismatches == 0 && cipher_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/hbc_pkg.sv
hw/rtl/hbc_blocker.sv
hw/rtl/hbc_rowmul.sv
hw/rtl/hbc_mod95.sv
hw/rtl/hill_block_cipher_mod95_unit.sv
verif/hill_cipher_check.sv
verif/hill_block_cipher_mod95_unit_test.sv
